>>> hdl/sstf_pkg.sv
// ----------------------------------------------------------------------------
// sstf_pkg: shared types and constants of the SSTF disk request scheduler
// Field widths, saturation limits and the scheduler state encoding.
// ----------------------------------------------------------------------------
package sstf_pkg;

	// Port field widths
	localparam int CYL_W   = 16;
	localparam int DIST_W  = 16;
	localparam int TOTAL_W = 22;
	localparam int SUM_W   = 23;
	localparam int M_TDATA_W = 56;

	// Saturation limits
	localparam logic [DIST_W-1:0]  DIST_MAX      = 16'hFFFF;
	localparam logic [TOTAL_W-1:0] SUM_MAX       = 22'h3FFFFF;
	localparam logic [SUM_W-1:0]   SUM_STATE_MAX = 23'h7FFFFF;

	// Command queue between front and back
	localparam int CMD_DEPTH = 4;
	localparam int CMD_AW    = 2;
	localparam int CMD_CW    = 3;

	// Control of the command channel from front to back
	typedef struct packed {
		logic valid;
		logic last;
	} cmd_ctl_t;

	// Back end states
	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SCAN,
		ST_WAIT,
		ST_EMIT
	} sched_state_t;

endpackage

>>> hdl/sstf_ram.sv
// ----------------------------------------------------------------------------
// sstf_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sstf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hdl/sstf_front.sv
// ----------------------------------------------------------------------------
// sstf_front: request intake
// Accepts request transfers, trims the cylinder and queues it for the back end.
// ----------------------------------------------------------------------------
module sstf_front #(
	parameter int CW = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [sstf_pkg::CYL_W-1:0]    s_tdata,
	input  logic                          s_tlast,
	output sstf_pkg::cmd_ctl_t            cmd_ctl,
	output logic [CW-1:0]                 cmd_cyl,
	input  logic                          cmd_ready
);

	logic [CW-1:0]               fifo_cyl_q  [sstf_pkg::CMD_DEPTH];
	logic                        fifo_last_q [sstf_pkg::CMD_DEPTH];
	logic [sstf_pkg::CMD_AW-1:0] wr_ptr_q;
	logic [sstf_pkg::CMD_AW-1:0] rd_ptr_q;
	logic [sstf_pkg::CMD_CW-1:0] fill_q;
	logic                        push;
	logic                        pop;

	// Handshake on both sides of the queue
	assign s_tready      = (fill_q != sstf_pkg::CMD_CW'(sstf_pkg::CMD_DEPTH));
	assign push          = s_tvalid && s_tready;
	assign cmd_ctl.valid = (fill_q != '0);
	assign cmd_ctl.last  = fifo_last_q[rd_ptr_q];
	assign cmd_cyl       = fifo_cyl_q[rd_ptr_q];
	assign pop           = cmd_ctl.valid && cmd_ready;

	// Store the cylinder trimmed to the configured width
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_cyl_q[wr_ptr_q]  <= CW'(s_tdata);
			fifo_last_q[wr_ptr_q] <= s_tlast;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

>>> hdl/sstf_back.sv
// ----------------------------------------------------------------------------
// sstf_back: request store and SSTF scheduler
// Loads queued requests, then scans the store once per selection and emits
// the nearest pending request through an output register.
// ----------------------------------------------------------------------------
module sstf_back #(
	parameter int QUEUE_DEPTH = 64,
	parameter int CW = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [sstf_pkg::CYL_W-1:0]      start_head,
	input  sstf_pkg::cmd_ctl_t              cmd_ctl,
	input  logic [CW-1:0]                   cmd_cyl,
	output logic                            cmd_ready,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [sstf_pkg::M_TDATA_W-1:0]  m_tdata,
	output logic                            m_tlast
);

	localparam int AW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
	localparam int DW   = (CW > sstf_pkg::DIST_W) ? CW : sstf_pkg::DIST_W;
	localparam int SW   = (CW + 1 > sstf_pkg::SUM_W + 1) ? CW + 1 : sstf_pkg::SUM_W + 1;

	sstf_pkg::sched_state_t state_q, state_d;

	logic [CNTW-1:0]               count_q;
	logic [CNTW-1:0]               remaining_q;
	logic [CNTW-1:0]               cnt_after;
	logic [AW-1:0]                 scan_idx_q;
	logic                          rd_pend_s1;
	logic [AW-1:0]                 idx_s1;
	logic [QUEUE_DEPTH-1:0]        valid_q;
	logic [CW-1:0]                 head_q;
	logic [sstf_pkg::SUM_W-1:0]    sum_q;
	logic                          found_q;
	logic [CW-1:0]                 best_q;
	logic [CW-1:0]                 best_cyl_q;
	logic [AW-1:0]                 pick_q;
	logic [CW-1:0]                 rd_data;
	logic [CW-1:0]                 seek_dist;
	logic                          take;
	logic                          pop;
	logic                          store;
	logic                          start;
	logic                          rd_en;
	logic                          scan_end;
	logic                          emit;
	logic                          batch_end;
	logic [DW-1:0]                 best_ext;
	logic [SW-1:0]                 sum_wide;
	logic [sstf_pkg::SUM_W-1:0]    sum_new;
	logic [sstf_pkg::DIST_W-1:0]   move_q;
	logic [sstf_pkg::TOTAL_W-1:0]  total_q;
	logic [sstf_pkg::CYL_W-1:0]    served_q;
	logic                          out_valid_q;
	logic                          out_last_q;

	// Pending request store
	sstf_ram #(
		.WIDTH(CW),
		.DEPTH(QUEUE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (store),
		.waddr(count_q[AW-1:0]),
		.wdata(cmd_cyl),
		.re   (rd_en),
		.raddr(scan_idx_q),
		.rdata(rd_data)
	);

	// Load side strobes
	assign cmd_ready = (state_q == sstf_pkg::ST_LOAD);
	assign pop       = cmd_ctl.valid && cmd_ready;
	assign store     = pop && (count_q < CNTW'(QUEUE_DEPTH));
	assign cnt_after = store ? count_q + 1'b1 : count_q;
	assign start     = pop && cmd_ctl.last && (cnt_after != '0);
	assign scan_end  = (CNTW'(scan_idx_q) == count_q - 1'b1);
	assign emit      = (state_q == sstf_pkg::ST_EMIT) && (!out_valid_q || m_tready);
	assign batch_end = emit && (remaining_q == CNTW'(1));

	// Next state
	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		case (state_q)
			sstf_pkg::ST_LOAD: begin
				if (start) begin
					state_d = sstf_pkg::ST_SCAN;
				end
			end
			sstf_pkg::ST_SCAN: begin
				rd_en = 1'b1;
				if (scan_end) begin
					state_d = sstf_pkg::ST_WAIT;
				end
			end
			sstf_pkg::ST_WAIT: begin
				state_d = sstf_pkg::ST_EMIT;
			end
			sstf_pkg::ST_EMIT: begin
				if (emit) begin
					state_d = batch_end ? sstf_pkg::ST_LOAD : sstf_pkg::ST_SCAN;
				end
			end
			default: begin
				state_d = sstf_pkg::ST_LOAD;
			end
		endcase
	end

	// Distance of the entry read last cycle; strict compare keeps the earliest
	assign seek_dist = (rd_data >= head_q) ? rd_data - head_q : head_q - rd_data;
	assign take = rd_pend_s1 && valid_q[idx_s1] && (!found_q || seek_dist < best_q);

	// Saturated distance and running sum of the chosen request
	assign best_ext = DW'(best_q);
	assign sum_wide = SW'(sum_q) + SW'(best_q);
	assign sum_new  = (sum_wide > SW'(sstf_pkg::SUM_STATE_MAX)) ?
	                  sstf_pkg::SUM_STATE_MAX : sum_wide[sstf_pkg::SUM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sstf_pkg::ST_LOAD;
			count_q     <= '0;
			remaining_q <= '0;
			scan_idx_q  <= '0;
			rd_pend_s1  <= 1'b0;
			idx_s1      <= '0;
			valid_q     <= '0;
			head_q      <= '0;
			sum_q       <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_pend_s1 <= rd_en;
			idx_s1     <= scan_idx_q;

			// Load a request and start the batch on its mark
			if (store) begin
				valid_q[count_q[AW-1:0]] <= 1'b1;
			end
			if (pop) begin
				count_q <= cnt_after;
			end
			if (pop && cmd_ctl.last) begin
				head_q      <= CW'(start_head);
				sum_q       <= '0;
				remaining_q <= cnt_after;
				scan_idx_q  <= '0;
				found_q     <= 1'b0;
			end

			// Advance the scan
			if (rd_en) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
			if (take) begin
				found_q <= 1'b1;
			end

			// Serve the chosen request
			if (emit) begin
				head_q          <= best_cyl_q;
				sum_q           <= sum_new;
				remaining_q     <= remaining_q - 1'b1;
				scan_idx_q      <= '0;
				found_q         <= 1'b0;
			end

			// Retire the served entry, or clear the whole queue at batch end
			if (batch_end) begin
				valid_q <= '0;
				count_q <= '0;
			end else if (emit) begin
				valid_q[pick_q] <= 1'b0;
			end

			// Hold the result until transfer
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Best candidate and result payload
	always_ff @(posedge clk) begin
		if (take) begin
			best_q     <= seek_dist;
			best_cyl_q <= rd_data;
			pick_q     <= idx_s1;
		end
		if (emit) begin
			served_q   <= sstf_pkg::CYL_W'(best_cyl_q);
			move_q     <= (best_ext > DW'(sstf_pkg::DIST_MAX)) ?
			              sstf_pkg::DIST_MAX : best_ext[sstf_pkg::DIST_W-1:0];
			total_q    <= (sum_new > sstf_pkg::SUM_W'(sstf_pkg::SUM_MAX)) ?
			              sstf_pkg::SUM_MAX : sum_new[sstf_pkg::TOTAL_W-1:0];
			out_last_q <= batch_end;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {2'b00, total_q, move_q, served_q};

endmodule

>>> hdl/sstf_disk_request_scheduler.sv
// Timing: a request passes through the front queue into the store; the first result
// follows the marked last request through a scan of the store, a wait state and the output register.
// Loading: requests leave the front queue only while the back end is loading; each result
// then needs a scan that reads every stored entry through the single RAM read port,
// so no new request enters the store until the whole batch has been served.
// Reset: asynchronous; clears queue, valid bits, head, sum and start_head, no sweep.
// ----------------------------------------------------------------------------
// sstf_disk_request_scheduler: shortest-seek-time-first disk request scheduler
// Collects a batch of cylinder requests and serves them nearest-first from a
// configured start head, reporting each move and the running total.
// ----------------------------------------------------------------------------
module sstf_disk_request_scheduler #(
	parameter int QUEUE_DEPTH   = 64,
	parameter int CYLINDER_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sstf_pkg::CYL_W-1:0]      cfg_wdata,   // start_head
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [sstf_pkg::CYL_W-1:0]      s_tdata,     // request_cylinder
	input  logic                            s_tlast,     // last_request
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// served_cylinder [15:0], move_distance [31:16], total_movement [53:32]
	output logic [sstf_pkg::M_TDATA_W-1:0]  m_tdata,
	output logic                            m_tlast      // last_served
);

	logic [sstf_pkg::CYL_W-1:0] start_head_q;
	sstf_pkg::cmd_ctl_t         cmd_ctl;
	logic [CYLINDER_BITS-1:0]   cmd_cyl;
	logic                       cmd_ready;

	// Start head register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_head_q <= '0;
		end else if (cfg_we) begin
			start_head_q <= cfg_wdata;
		end
	end

	sstf_front #(
		.CW(CYLINDER_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.cmd_ctl  (cmd_ctl),
		.cmd_cyl  (cmd_cyl),
		.cmd_ready(cmd_ready)
	);

	sstf_back #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.CW         (CYLINDER_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.start_head(start_head_q),
		.cmd_ctl   (cmd_ctl),
		.cmd_cyl   (cmd_cyl),
		.cmd_ready (cmd_ready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
